// ===== rtl/pds_pkg.sv =====
`timescale 1ns / 1ps
// Package: constants, types and status codes shared by the PLL divider search block.
package pds_pkg;

    // Search ranges
    localparam int MAX_PRE_DIV  = 4;
    localparam int MIN_MULT     = 4;
    localparam int MAX_MULT     = 127;
    localparam int MAX_POST_DIV = 4;

    // Fixed field widths
    localparam int REF_W        = 32;
    localparam int RATE_W       = 32;
    localparam int CFG_W        = 22;
    localparam int COARSE_SHIFT = 10;
    localparam int PRE_OUT_W    = 3;
    localparam int MULT_OUT_W   = 7;
    localparam int POST_OUT_W   = 3;
    localparam int STATUS_W     = 2;

    // Derived widths
    localparam int PHASE_W    = REF_W - COARSE_SHIFT;
    localparam int PRE_W      = $clog2(MAX_PRE_DIV + 1);
    localparam int MULT_W     = $clog2(MAX_MULT + 1);
    localparam int POST_W     = $clog2(MAX_POST_DIV + 1);
    localparam int POST_IDX_W = (MAX_POST_DIV > 1) ? $clog2(MAX_POST_DIV) : 1;
    localparam int DIVISOR_W  = $clog2(MAX_PRE_DIV * MAX_POST_DIV + 1);
    localparam int VCO_W      = PHASE_W + MULT_W;
    localparam int EXACT_W    = REF_W + MULT_W;

    // Stream and register port widths
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = STATUS_W;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    // Register map, one word per register
    typedef enum logic [REG_IDX_W-1:0] {
        REG_PHASE_MIN     = 3'd0,
        REG_PHASE_MAX     = 3'd1,
        REG_VCO_MIN       = 3'd2,
        REG_VCO_MAX       = 3'd3,
        REG_COARSE_WINDOW = 3'd4
    } reg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_FOUND   = 2'd0,
        STATUS_TOO_LOW = 2'd1,
        STATUS_NONE    = 2'd2
    } status_t;

    typedef struct packed {
        logic [CFG_W-1:0] phase_min;
        logic [CFG_W-1:0] phase_max;
        logic [CFG_W-1:0] vco_min;
        logic [CFG_W-1:0] vco_max;
        logic [CFG_W-1:0] coarse_window;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic                  load;
        logic                  div_start;
        logic                  walk;
        logic                  result_load;
        logic [PRE_W-1:0]      pre;
        logic [POST_IDX_W-1:0] pidx;
        logic [MULT_W-1:0]     mult;
    } pds_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic tcoarse_zero;
        logic div_done;
        logic phase_ok;
        logic pipe_busy;
        logic out_full;
    } pds_sts_t;

endpackage

// ===== rtl/pds_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, small divisor.
module pds_div
    import pds_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [REF_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [REF_W-1:0]     quotient,
    output logic [DIVISOR_W-1:0] remainder
);

    localparam int CNT_W = $clog2(REF_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [REF_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [DIVISOR_W:0]   trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[REF_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(REF_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // partial remainder stays below the divisor
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = DIVISOR_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[REF_W-2:0], 1'b1};
            end else begin
                rem_next = DIVISOR_W'(trial);
                quo_next = {quo_reg[REF_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

// ===== rtl/pds_dp.sv =====
`timescale 1ns / 1ps
// Datapath: divider, per-post accumulators, candidate pipeline, best tracking, result register.
module pds_dp
    import pds_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pds_cmd_t             cmd,
    output pds_sts_t             sts,
    input  cfg_t                 cfg,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    // input transaction
    logic [REF_W-1:0]   ref_reg;
    logic [RATE_W-1:0]  target_reg;
    logic [PHASE_W-1:0] tcoarse;

    // divider
    logic                 div_done;
    logic [REF_W-1:0]     div_quo;
    logic [DIVISOR_W-1:0] div_rem;

    // loop position decode
    logic [POST_IDX_W-1:0]      idx;
    logic [POST_W-1:0]          post;
    logic [PRE_W+POST_W-1:0]    d_full;
    logic [DIVISOR_W-1:0]       d;
    logic                       mult_ok;

    // per-pre setup values
    logic [PHASE_W-1:0]        phase_reg;
    logic [VCO_W-1:0]          vco_reg;
    logic [PHASE_W-1:0]        dq_coarse;
    logic [PHASE_W-1:0]        phase_src;
    logic [PHASE_W+POST_W-1:0] cq_prod;
    logic [PHASE_W+POST_W-1:0] cr_full;
    logic [POST_W-1:0]         cr_new;

    // per-post steps and running quotient/remainder pairs
    logic [REF_W-1:0]     step_q_reg  [MAX_POST_DIV];
    logic [DIVISOR_W-1:0] step_r_reg  [MAX_POST_DIV];
    logic [PHASE_W-1:0]   step_cq_reg [MAX_POST_DIV];
    logic [POST_W-1:0]    step_cr_reg [MAX_POST_DIV];
    logic [EXACT_W-1:0]   acc_q_reg   [MAX_POST_DIV];
    logic [DIVISOR_W-1:0] acc_r_reg   [MAX_POST_DIV];
    logic [VCO_W-1:0]     acc_cq_reg  [MAX_POST_DIV];
    logic [POST_W-1:0]    acc_cr_reg  [MAX_POST_DIV];

    logic [DIVISOR_W:0]   r_sum;
    logic                 r_wrap;
    logic [DIVISOR_W-1:0] acc_r_next;
    logic [EXACT_W-1:0]   acc_q_next;
    logic [POST_W:0]      cr_sum;
    logic                 cr_wrap;
    logic [POST_W-1:0]    acc_cr_next;
    logic [VCO_W-1:0]     acc_cq_next;

    // stage A: raw candidate
    logic                a_valid_reg;
    logic [EXACT_W-1:0]  a_exact_reg;
    logic [VCO_W-1:0]    a_coarse_reg;
    logic [VCO_W-1:0]    a_vco_reg;
    logic [PRE_W-1:0]    a_pre_reg;
    logic [MULT_W-1:0]   a_mult_reg;
    logic [POST_W-1:0]   a_post_reg;

    // stage B: filtered candidate
    logic [VCO_W-1:0]   tcoarse_ext;
    logic [VCO_W-1:0]   cdiff;
    logic               coarse_ok;
    logic               vco_ok;
    logic               fits;
    logic [RATE_W-1:0]  exact32;
    logic [RATE_W-1:0]  err;
    logic               b_valid_reg;
    logic [RATE_W-1:0]  b_err_reg;
    logic [CFG_W-1:0]   b_vco_reg;
    logic [RATE_W-1:0]  b_rate_reg;
    logic [PRE_W-1:0]   b_pre_reg;
    logic [MULT_W-1:0]  b_mult_reg;
    logic [POST_W-1:0]  b_post_reg;

    // stage C: best so far
    logic               take;
    logic               found_reg;
    logic [RATE_W-1:0]  best_err_reg;
    logic [CFG_W-1:0]   best_vco_reg;
    logic [RATE_W-1:0]  best_rate_reg;
    logic [PRE_W-1:0]   best_pre_reg;
    logic [MULT_W-1:0]  best_mult_reg;
    logic [POST_W-1:0]  best_post_reg;

    // result register
    logic                  out_valid_reg;
    logic [PRE_OUT_W-1:0]  out_pre_reg,  out_pre_next;
    logic [MULT_OUT_W-1:0] out_mult_reg, out_mult_next;
    logic [POST_OUT_W-1:0] out_post_reg, out_post_next;
    logic [RATE_W-1:0]     out_rate_reg, out_rate_next;
    status_t               out_status_reg, out_status_next;

    assign tcoarse = target_reg[RATE_W-1:COARSE_SHIFT];

    assign idx     = cmd.pidx;
    assign post    = POST_W'(cmd.pidx) + POST_W'(1);
    assign d_full  = {{POST_W{1'b0}}, cmd.pre} * {{PRE_W{1'b0}}, post};
    assign d       = DIVISOR_W'(d_full);
    assign mult_ok = int'(cmd.mult) >= MIN_MULT;

    pds_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (ref_reg),
        .divisor   (d),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // ref/(pre*post) >> 10 equals (phase)/post; remainder recovered by multiply-back
    assign dq_coarse = div_quo[REF_W-1:COARSE_SHIFT];
    assign phase_src = (idx == '0) ? dq_coarse : phase_reg;
    assign cq_prod   = {{POST_W{1'b0}}, dq_coarse} * {{PHASE_W{1'b0}}, post};
    assign cr_full   = {{POST_W{1'b0}}, phase_src} - cq_prod;
    assign cr_new    = POST_W'(cr_full);

    // step the selected pair by one multiplier increment
    always_comb begin
        r_sum       = {1'b0, acc_r_reg[idx]} + {1'b0, step_r_reg[idx]};
        r_wrap      = r_sum >= {1'b0, d};
        acc_r_next  = DIVISOR_W'(r_wrap ? (r_sum - {1'b0, d}) : r_sum);
        acc_q_next  = acc_q_reg[idx] + EXACT_W'(step_q_reg[idx]) + EXACT_W'(r_wrap);
        cr_sum      = {1'b0, acc_cr_reg[idx]} + {1'b0, step_cr_reg[idx]};
        cr_wrap     = cr_sum >= {1'b0, post};
        acc_cr_next = POST_W'(cr_wrap ? (cr_sum - {1'b0, post}) : cr_sum);
        acc_cq_next = acc_cq_reg[idx] + VCO_W'(step_cq_reg[idx]) + VCO_W'(cr_wrap);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ref_reg    <= s_tdata[REF_W-1:0];
            target_reg <= s_tdata[REF_W+RATE_W-1:REF_W];
        end
        if (div_done) begin
            step_q_reg[idx]  <= div_quo;
            step_r_reg[idx]  <= div_rem;
            step_cq_reg[idx] <= dq_coarse;
            step_cr_reg[idx] <= cr_new;
            acc_q_reg[idx]   <= '0;
            acc_r_reg[idx]   <= '0;
            acc_cq_reg[idx]  <= '0;
            acc_cr_reg[idx]  <= '0;
            if (idx == '0) begin
                phase_reg <= dq_coarse;
                vco_reg   <= '0;
            end
        end else if (cmd.walk) begin
            acc_q_reg[idx]  <= acc_q_next;
            acc_r_reg[idx]  <= acc_r_next;
            acc_cq_reg[idx] <= acc_cq_next;
            acc_cr_reg[idx] <= acc_cr_next;
            if (idx == POST_IDX_W'(MAX_POST_DIV - 1)) begin
                vco_reg <= vco_reg + VCO_W'(phase_reg);
            end
        end
    end

    // stage A
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= cmd.walk && mult_ok;
        end
        a_exact_reg  <= acc_q_reg[idx];
        a_coarse_reg <= acc_cq_reg[idx];
        a_vco_reg    <= vco_reg;
        a_pre_reg    <= cmd.pre;
        a_mult_reg   <= cmd.mult;
        a_post_reg   <= post;
    end

    // stage B: windows and distance
    assign tcoarse_ext = VCO_W'(tcoarse);
    assign cdiff       = (a_coarse_reg >= tcoarse_ext) ? (a_coarse_reg - tcoarse_ext)
                                                       : (tcoarse_ext - a_coarse_reg);
    assign coarse_ok   = cdiff <= VCO_W'(cfg.coarse_window);
    assign vco_ok      = (a_vco_reg >= VCO_W'(cfg.vco_min)) && (a_vco_reg <= VCO_W'(cfg.vco_max));
    assign fits        = a_exact_reg[EXACT_W-1:RATE_W] == '0;
    assign exact32     = a_exact_reg[RATE_W-1:0];
    assign err         = (exact32 >= target_reg) ? (exact32 - target_reg)
                                                 : (target_reg - exact32);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= a_valid_reg && vco_ok && coarse_ok && fits;
        end
        b_err_reg  <= err;
        b_vco_reg  <= CFG_W'(a_vco_reg);   // kept vco never exceeds vco_max
        b_rate_reg <= exact32;
        b_pre_reg  <= a_pre_reg;
        b_mult_reg <= a_mult_reg;
        b_post_reg <= a_post_reg;
    end

    // stage C: nearest wins, then lower vco, then earlier
    assign take = b_valid_reg && (!found_reg || (b_err_reg < best_err_reg) ||
                  ((b_err_reg == best_err_reg) && (b_vco_reg < best_vco_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.load) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
        if (take) begin
            best_err_reg  <= b_err_reg;
            best_vco_reg  <= b_vco_reg;
            best_rate_reg <= b_rate_reg;
            best_pre_reg  <= b_pre_reg;
            best_mult_reg <= b_mult_reg;
            best_post_reg <= b_post_reg;
        end
    end

    // result
    always_comb begin
        out_pre_next    = '0;
        out_mult_next   = '0;
        out_post_next   = '0;
        out_rate_next   = '0;
        out_status_next = STATUS_FOUND;
        if (tcoarse == '0) begin
            out_status_next = STATUS_TOO_LOW;
        end else if (!found_reg) begin
            out_status_next = STATUS_NONE;
        end else begin
            out_pre_next  = PRE_OUT_W'(best_pre_reg);
            out_mult_next = MULT_OUT_W'(best_mult_reg);
            out_post_next = POST_OUT_W'(best_post_reg);
            out_rate_next = best_rate_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.result_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.result_load) begin
            out_pre_reg    <= out_pre_next;
            out_mult_reg   <= out_mult_next;
            out_post_reg   <= out_post_next;
            out_rate_reg   <= out_rate_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - PRE_OUT_W - MULT_OUT_W - POST_OUT_W - RATE_W){1'b0}},
                       out_rate_reg, out_post_reg, out_mult_reg, out_pre_reg};
    assign m_tuser  = out_status_reg;

    assign sts.tcoarse_zero = tcoarse == '0;
    assign sts.div_done     = div_done;
    assign sts.phase_ok     = (phase_reg >= cfg.phase_min) && (phase_reg <= cfg.phase_max);
    assign sts.pipe_busy    = a_valid_reg || b_valid_reg;
    assign sts.out_full     = out_valid_reg;

    a_found_from_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(found_reg) |-> $past(b_valid_reg))
        else $error("best candidate set without a filtered candidate");

    a_no_walk_during_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> !cmd.walk)
        else $error("division finished during the multiplier walk");

endmodule

// ===== rtl/pds_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences setup divisions, the divider walk and result hand-off.
module pds_ctrl
    import pds_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  pds_sts_t sts,
    output pds_cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_IDLE        = 8'b0000_0001,
        ST_TEST        = 8'b0000_0010,
        ST_DIV_START   = 8'b0000_0100,
        ST_DIV_WAIT    = 8'b0000_1000,
        ST_PHASE_CHECK = 8'b0001_0000,
        ST_WALK        = 8'b0010_0000,
        ST_DRAIN       = 8'b0100_0000,
        ST_FINISH      = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [PRE_W-1:0]      pre_reg, pre_next;
    logic [POST_IDX_W-1:0] pidx_reg, pidx_next;
    logic [MULT_W-1:0]     mult_reg, mult_next;
    logic                  last_pre;
    logic                  last_pidx;
    logic                  last_mult;

    assign last_pre  = pre_reg == PRE_W'(MAX_PRE_DIV);
    assign last_pidx = pidx_reg == POST_IDX_W'(MAX_POST_DIV - 1);
    assign last_mult = mult_reg == MULT_W'(MAX_MULT);

    always_comb begin
        state_next      = state_reg;
        pre_next        = pre_reg;
        pidx_next       = pidx_reg;
        mult_next       = mult_reg;
        cmd             = '0;
        cmd.pre         = pre_reg;
        cmd.pidx        = pidx_reg;
        cmd.mult        = mult_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (sts.tcoarse_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    pre_next   = PRE_W'(1);
                    pidx_next  = '0;
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (sts.div_done) begin
                    if (pidx_reg == '0) begin
                        state_next = ST_PHASE_CHECK;
                    end else if (last_pidx) begin
                        pidx_next  = '0;
                        mult_next  = '0;
                        state_next = ST_WALK;
                    end else begin
                        pidx_next  = pidx_reg + 1'b1;
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_PHASE_CHECK: begin
                if (!sts.phase_ok) begin
                    if (last_pre) begin
                        state_next = ST_DRAIN;
                    end else begin
                        pre_next   = pre_reg + 1'b1;
                        pidx_next  = '0;
                        state_next = ST_DIV_START;
                    end
                end else if (last_pidx) begin
                    pidx_next  = '0;
                    mult_next  = '0;
                    state_next = ST_WALK;
                end else begin
                    pidx_next  = pidx_reg + 1'b1;
                    state_next = ST_DIV_START;
                end
            end
            ST_WALK: begin
                cmd.walk = 1'b1;
                if (last_pidx) begin
                    pidx_next = '0;
                    if (last_mult) begin
                        if (last_pre) begin
                            state_next = ST_DRAIN;
                        end else begin
                            pre_next   = pre_reg + 1'b1;
                            state_next = ST_DIV_START;
                        end
                    end else begin
                        mult_next = mult_reg + 1'b1;
                    end
                end else begin
                    pidx_next = pidx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!sts.out_full) begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pre_reg   <= '0;
            pidx_reg  <= '0;
            mult_reg  <= '0;
        end else begin
            state_reg <= state_next;
            pre_reg   <= pre_next;
            pidx_reg  <= pidx_next;
            mult_reg  <= mult_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;

    a_load_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.result_load |-> !sts.out_full)
        else $error("result loaded over an untaken result");

    a_walk_pre_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk |-> (pre_reg != '0) && (pre_reg <= PRE_W'(MAX_PRE_DIV)))
        else $error("walk with pre-divider out of range");

endmodule

// ===== rtl/pll_divider_search_top.sv =====
`timescale 1ns / 1ps
// Top level: PLL divider search with stream ports and register port.
// A target below 1024 Hz skips the search. Otherwise setup divisions run for each of
//   P = pre-dividers (4), and the walk for W = those whose phase clock lies in window.
// Throughput: one transaction at a time; set by the shared divider (up to four
//   divisions per pre-divider) and the walk of one divider triple per cycle.
// A finished result waits in the output register while the next transaction is taken.
// Reset: aresetn synchronous, active low; registers return to their defaults, block idle.
module pll_divider_search_top
    import pds_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // input transactions
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] reference_rate, [63:32] target_rate

    // result transactions
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [2:0] pre_divider, [9:3] multiplier,
                                            // [12:10] post_divider, [44:13] achieved_rate
    output logic [M_TUSER_W-1:0] m_tuser,   // [1:0] status

    // register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    // defaults in 1024 Hz units
    localparam logic [CFG_W-1:0] PHASE_MIN_RST     = 22'd976;
    localparam logic [CFG_W-1:0] PHASE_MAX_RST     = 22'd4882;
    localparam logic [CFG_W-1:0] VCO_MIN_RST       = 22'd122070;
    localparam logic [CFG_W-1:0] VCO_MAX_RST       = 22'd1464843;
    localparam logic [CFG_W-1:0] COARSE_WINDOW_RST = 22'd10000;

    cfg_t                 cfg_reg, cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     wr_val;
    pds_cmd_t             cmd;
    pds_sts_t             sts;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_val  = pwdata[CFG_W-1:0];

    // register writes; addresses past the map are ignored
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_PHASE_MIN:     cfg_next.phase_min     = wr_val;
                REG_PHASE_MAX:     cfg_next.phase_max     = wr_val;
                REG_VCO_MIN:       cfg_next.vco_min       = wr_val;
                REG_VCO_MAX:       cfg_next.vco_max       = wr_val;
                REG_COARSE_WINDOW: cfg_next.coarse_window = wr_val;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phase_min     <= PHASE_MIN_RST;
            cfg_reg.phase_max     <= PHASE_MAX_RST;
            cfg_reg.vco_min       <= VCO_MIN_RST;
            cfg_reg.vco_max       <= VCO_MAX_RST;
            cfg_reg.coarse_window <= COARSE_WINDOW_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb begin
        unique case (reg_idx)
            REG_PHASE_MIN:     prdata = PDATA_W'(cfg_reg.phase_min);
            REG_PHASE_MAX:     prdata = PDATA_W'(cfg_reg.phase_max);
            REG_VCO_MIN:       prdata = PDATA_W'(cfg_reg.vco_min);
            REG_VCO_MAX:       prdata = PDATA_W'(cfg_reg.vco_max);
            REG_COARSE_WINDOW: prdata = PDATA_W'(cfg_reg.coarse_window);
            default:           prdata = '0;
        endcase
    end

    // sequencer: setup divisions per pre-divider, then the multiplier/post walk
    pds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic, best-candidate tracking and output register
    pds_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .cfg      (cfg_reg),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
